FILE: src/boxds_pkg.sv
package boxds_pkg;

	// Register and field widths
	localparam int SCALE_W   = 5;
	localparam int DIM_W     = 13;
	localparam int PIX_W     = 16;
	localparam int OUT_W     = 16;
	localparam int SUM_W     = 24;
	localparam int CFG_IDX_W = 2;

	// Block geometry limits
	localparam int MAX_SCALE = 16;
	localparam int BLK_W     = $clog2(MAX_SCALE);
	localparam int ROW_LIMIT = 4096;
	localparam int ROW_W     = $clog2(ROW_LIMIT);

	// Divisor (scale squared) and its reciprocal
	localparam int DIV_W   = 2 * $clog2(MAX_SCALE) + 1;
	localparam int RECIP_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE,
		REG_IMAGE_COLS,
		REG_IMAGE_ROWS
	} cfg_reg_t;

	// floor((2^32 - 1) / (s * s)); the quotient estimate is at most one low
	function automatic logic [RECIP_W-1:0] recip_of(input logic [SCALE_W-1:0] s);
		logic [RECIP_W-1:0] r;
		case (s)
			5'd1:    r = 32'hFFFF_FFFF;
			5'd2:    r = 32'h3FFF_FFFF;
			5'd3:    r = 32'h1C71_C71C;
			5'd4:    r = 32'h0FFF_FFFF;
			5'd5:    r = 32'h0A3D_70A3;
			5'd6:    r = 32'h071C_71C7;
			5'd7:    r = 32'h0539_7829;
			5'd8:    r = 32'h03FF_FFFF;
			5'd9:    r = 32'h0329_161F;
			5'd10:   r = 32'h028F_5C28;
			5'd11:   r = 32'h021D_9EAD;
			5'd12:   r = 32'h01C7_1C71;
			5'd13:   r = 32'h0183_C977;
			5'd14:   r = 32'h014E_5E0A;
			5'd15:   r = 32'h0123_4567;
			5'd16:   r = 32'h00FF_FFFF;
			default: r = 32'hFFFF_FFFF;
		endcase
		return r;
	endfunction

endpackage

FILE: src/boxds_ram.sv
module boxds_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; a read returns the old contents
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: src/box_average_downscale_core.sv
// Box-filter downscaler for a grayscale pixel stream.
// Pixels enter in raster order on the in_valid/in_ready channel, one item per
// clock when the output side keeps up. Every scale-by-scale block of pixels
// gives one averaged item on the out_valid/out_ready channel, sum divided by
// scale squared and truncated; frame_last marks the final block of a frame.
// Edge rows and columns that do not fill a whole block are taken and dropped.
// Datapath: the result of the pixel completing its block passes the sum
// memory read with accumulate, reciprocal multiply, remainder and
// correction into the queue, then it sits in an 8-entry queue.
// Throughput: one pixel per cycle outside stalls, set by the read-modify-write
// of the column sum memory, which forwards the last write to the next read.
// Stalls: up to 8 results may be owed to the receiver; when 8 are owed,
// in_ready drops until one is taken. No result is ever dropped.
// Reset and configuration: scale=2, 640x480. Writing scale (index 0),
// image_cols (1) or image_rows (2) restarts the frame at its first pixel.
// The sum memory needs no clearing: the first pixel of each block overwrites
// its entry.
module box_average_downscale_core #(
	parameter int MAX_COLS = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [boxds_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [boxds_pkg::DIM_W-1:0]     cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [boxds_pkg::PIX_W-1:0]     pixel,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [boxds_pkg::OUT_W-1:0]     avg_pixel,
	output logic                           frame_last
);

	import boxds_pkg::*;

	localparam int COL_W      = $clog2(MAX_COLS);
	localparam int CNT_W      = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
	localparam int EXT_W      = CNT_W + 1;
	localparam int RX_W       = DIM_W + 1;
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int OCC_W      = FIFO_AW + 1;
	localparam int PROD_W     = SUM_W + RECIP_W;
	localparam int QD_W       = SUM_W + DIV_W;

	// Configuration registers
	logic [SCALE_W-1:0] scale_q;
	logic [DIM_W-1:0]   cols_q;
	logic [DIM_W-1:0]   rows_q;
	logic               restart;

	// Frame position
	logic [COL_W-1:0] col_pos_q;
	logic [COL_W-1:0] col_start_q;
	logic [COL_W-1:0] out_col_q;
	logic [ROW_W-1:0] row_pos_q;
	logic [ROW_W-1:0] row_start_q;
	logic [BLK_W-1:0] cib_q;
	logic [BLK_W-1:0] rib_q;

	// Clamped geometry
	logic [SCALE_W-1:0] s_eff;
	logic [CNT_W-1:0]   cols_eff;
	logic [DIM_W-1:0]   rows_eff;

	// Per-pixel decode
	logic               accept;
	logic               col_fit, row_fit, col_lastblk, row_lastblk;
	logic               active, blk_first, blk_done;
	logic [CNT_W-1:0]   col_pos_inc;
	logic [DIM_W-1:0]   row_pos_inc;
	logic [SCALE_W-1:0] cib_inc, rib_inc;
	logic               col_wrap, row_wrap, cib_wrap, rib_wrap;

	// Accumulate stage
	logic               v_s1, first_s1, done_s1, last_s1;
	logic [PIX_W-1:0]   px_s1;
	logic [COL_W-1:0]   addr_s1;
	logic [SUM_W-1:0]   ram_rdata, fwd_data, sum_s1;
	logic               wr_v_q;
	logic [COL_W-1:0]   wr_addr_q;
	logic [SUM_W-1:0]   wr_data_q;

	// Divide stages
	logic [RECIP_W-1:0] recip_q;
	logic [DIV_W-1:0]   dsq_q;
	logic               v_s2, last_s2;
	logic [SUM_W-1:0]   sum_s2;
	logic [PROD_W-1:0]  prod;
	logic               v_s3, last_s3;
	logic [SUM_W-1:0]   sum_s3, q_s3;
	logic [QD_W-1:0]    qd, rem;
	logic               v_s4, last_s4;
	logic [SUM_W-1:0]   q_s4, q_fin;
	logic [DIV_W:0]     r_s4;

	// Output queue
	logic [OUT_W-1:0]   fifo_avg [FIFO_DEPTH];
	logic               fifo_last [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [OCC_W-1:0]   cnt_q, occ_q;
	logic               push, pop, owe;

	// Register writes; any known index restarts the frame
	assign restart = cfg_wr_en && (cfg_index == REG_SCALE || cfg_index == REG_IMAGE_COLS ||
		cfg_index == REG_IMAGE_ROWS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_W'(2);
			cols_q  <= DIM_W'(640);
			rows_q  <= DIM_W'(480);
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_SCALE:      scale_q <= cfg_wdata[SCALE_W-1:0];
				REG_IMAGE_COLS: cols_q  <= cfg_wdata;
				REG_IMAGE_ROWS: rows_q  <= cfg_wdata;
				default:        ;
			endcase
		end
	end

	// Clamp geometry into the supported range
	always_comb begin
		if (scale_q == '0) begin
			s_eff = SCALE_W'(1);
		end else if (scale_q > SCALE_W'(MAX_SCALE)) begin
			s_eff = SCALE_W'(MAX_SCALE);
		end else begin
			s_eff = scale_q;
		end
		if (cols_q == '0) begin
			cols_eff = CNT_W'(1);
		end else if (CNT_W'(cols_q) > CNT_W'(MAX_COLS)) begin
			cols_eff = CNT_W'(MAX_COLS);
		end else begin
			cols_eff = CNT_W'(cols_q);
		end
		if (rows_q == '0) begin
			rows_eff = DIM_W'(1);
		end else if (rows_q > DIM_W'(ROW_LIMIT)) begin
			rows_eff = DIM_W'(ROW_LIMIT);
		end else begin
			rows_eff = rows_q;
		end
	end

	// Decode the position of the pixel on the input port
	assign accept      = in_valid && in_ready;
	assign col_fit     = EXT_W'(col_start_q) + EXT_W'(s_eff) <= EXT_W'(cols_eff);
	assign col_lastblk = EXT_W'(col_start_q) + EXT_W'(s_eff) + EXT_W'(s_eff) > EXT_W'(cols_eff);
	assign row_fit     = RX_W'(row_start_q) + RX_W'(s_eff) <= RX_W'(rows_eff);
	assign row_lastblk = RX_W'(row_start_q) + RX_W'(s_eff) + RX_W'(s_eff) > RX_W'(rows_eff);
	assign active      = col_fit && row_fit;
	assign blk_first   = (cib_q == '0) && (rib_q == '0);
	assign blk_done    = (SCALE_W'(cib_q) == s_eff - SCALE_W'(1)) &&
		(SCALE_W'(rib_q) == s_eff - SCALE_W'(1));

	assign col_pos_inc = CNT_W'(col_pos_q) + CNT_W'(1);
	assign row_pos_inc = DIM_W'(row_pos_q) + DIM_W'(1);
	assign cib_inc     = SCALE_W'(cib_q) + SCALE_W'(1);
	assign rib_inc     = SCALE_W'(rib_q) + SCALE_W'(1);
	assign col_wrap    = col_pos_inc >= cols_eff;
	assign row_wrap    = row_pos_inc >= rows_eff;
	assign cib_wrap    = cib_inc >= s_eff;
	assign rib_wrap    = rib_inc >= s_eff;

	// Advance the raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_pos_q   <= '0;
			col_start_q <= '0;
			out_col_q   <= '0;
			row_pos_q   <= '0;
			row_start_q <= '0;
			cib_q       <= '0;
			rib_q       <= '0;
		end else if (restart) begin
			col_pos_q   <= '0;
			col_start_q <= '0;
			out_col_q   <= '0;
			row_pos_q   <= '0;
			row_start_q <= '0;
			cib_q       <= '0;
			rib_q       <= '0;
		end else if (accept) begin
			col_pos_q <= col_pos_inc[COL_W-1:0];
			cib_q     <= cib_inc[BLK_W-1:0];
			if (cib_wrap) begin
				cib_q       <= '0;
				out_col_q   <= out_col_q + COL_W'(1);
				col_start_q <= col_pos_inc[COL_W-1:0];
			end
			if (col_wrap) begin
				col_pos_q   <= '0;
				cib_q       <= '0;
				out_col_q   <= '0;
				col_start_q <= '0;
				row_pos_q   <= row_pos_inc[ROW_W-1:0];
				rib_q       <= rib_inc[BLK_W-1:0];
				if (rib_wrap) begin
					rib_q       <= '0;
					row_start_q <= row_pos_inc[ROW_W-1:0];
				end
				if (row_wrap) begin
					row_pos_q   <= '0;
					rib_q       <= '0;
					row_start_q <= '0;
				end
			end
		end
	end

	// Column sum memory
	boxds_ram #(
		.WIDTH(SUM_W),
		.DEPTH(MAX_COLS)
	) u_sums (
		.clk    (clk),
		.wr_en  (v_s1),
		.wr_addr(addr_s1),
		.wr_data(sum_s1),
		.rd_en  (accept && active),
		.rd_addr(out_col_q),
		.rd_data(ram_rdata)
	);

	// Hold the pixel while its column sum is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept && active;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1    <= pixel;
			first_s1 <= blk_first;
			done_s1  <= blk_done;
			last_s1  <= col_lastblk && row_lastblk;
			addr_s1  <= out_col_q;
		end
	end

	// Forward the previous write over the memory read, then accumulate
	assign fwd_data = (wr_v_q && wr_addr_q == addr_s1) ? wr_data_q : ram_rdata;
	assign sum_s1   = first_s1 ? SUM_W'(px_s1) : fwd_data + SUM_W'(px_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_v_q <= 1'b0;
		end else if (v_s1) begin
			wr_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			wr_addr_q <= addr_s1;
			wr_data_q <= sum_s1;
		end
	end

	// Divisor and reciprocal follow the clamped scale
	always_ff @(posedge clk) begin
		recip_q <= recip_of(s_eff);
		dsq_q   <= DIV_W'(s_eff) * DIV_W'(s_eff);
	end

	// Divide pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && done_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Quotient estimate by reciprocal, remainder, one-step correction
	assign prod  = PROD_W'(sum_s2) * PROD_W'(recip_q);
	assign qd    = QD_W'(q_s3) * QD_W'(dsq_q);
	assign rem   = QD_W'(sum_s3) - qd;
	assign q_fin = (r_s4 >= {1'b0, dsq_q}) ? q_s4 + SUM_W'(1) : q_s4;

	always_ff @(posedge clk) begin
		sum_s2  <= sum_s1;
		last_s2 <= last_s1;
		q_s3    <= prod[PROD_W-1:RECIP_W];
		sum_s3  <= sum_s2;
		last_s3 <= last_s2;
		q_s4    <= q_s3;
		r_s4    <= rem[DIV_W:0];
		last_s4 <= last_s3;
	end

	// Output queue
	assign push      = v_s4;
	assign pop       = out_valid && out_ready;
	assign owe       = accept && active && blk_done;
	assign out_valid = cnt_q != '0;
	assign avg_pixel = fifo_avg[rd_ptr_q];
	assign frame_last = fifo_last[rd_ptr_q];
	assign in_ready  = occ_q != OCC_W'(FIFO_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_avg[wr_ptr_q]  <= q_fin[OUT_W-1:0];
			fifo_last[wr_ptr_q] <= last_s4;
		end
	end

	// Track queue fill and results owed to the receiver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			occ_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + OCC_W'(1);
			end else if (!push && pop) begin
				cnt_q <= cnt_q - OCC_W'(1);
			end
			if (owe && !pop) begin
				occ_q <= occ_q + OCC_W'(1);
			end else if (!owe && pop) begin
				occ_q <= occ_q - OCC_W'(1);
			end
		end
	end

	// Checks
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(FIFO_DEPTH))
		else $error("more results owed than the output queue holds");

	a_queue_le_owed: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= occ_q)
		else $error("output queue holds more items than are owed");

	a_col_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		SCALE_W'(cib_q) < s_eff && SCALE_W'(rib_q) < s_eff)
		else $error("position inside block outside the scale");

	a_push_was_owed: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> occ_q != '0)
		else $error("result produced that was never counted");

endmodule

FILE: test/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import boxds_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE      = 12;
	localparam int COL_LIMIT   = 4096;

	typedef struct packed {
		logic [OUT_W-1:0] avg;
		logic             last;
	} block_avg_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_wdata;
	logic                 in_valid;
	logic                 in_ready;
	logic [PIX_W-1:0]     pixel;
	logic                 out_valid;
	logic                 out_ready;
	logic [OUT_W-1:0]     avg_pixel;
	logic                 frame_last;

	// Downscaler state as the predictor sees it
	logic [SCALE_W-1:0] scale_reg;
	logic [DIM_W-1:0]   cols_reg;
	logic [DIM_W-1:0]   rows_reg;
	logic [SUM_W-1:0]   col_sums [0:COL_LIMIT-1];
	int                 cur_col, cur_row, blk_x, blk_y, blk_idx;

	block_avg_t  pending_blocks [$];
	block_avg_t  seen_want;
	int          errors = 0;
	int unsigned cycle_count = 0;
	bit          in_idle_on = 1'b0;
	bit          out_idle_on = 1'b0;
	int          out_hold = 0;

	box_average_downscale_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel      (pixel),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.avg_pixel  (avg_pixel),
		.frame_last (frame_last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d items still owed", $time, pending_blocks.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [PIX_W-1:0] rand_pixel();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return PIX_W'($urandom_range(0, 65535));
	endfunction

	function automatic int clamp_dim(input int v, input int hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Stall the receiving side
	always @(negedge clk) begin
		if (out_hold != 0) begin
			out_hold <= out_hold - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (out_idle_on && $urandom_range(0, 3) == 0)
				out_hold <= idle_gap();
		end
	end

	// Compare each delivered item with the oldest owed block average
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_blocks.size() == 0) begin
				$display("%0t: expected no item, got avg_pixel %0d frame_last %0b",
					$time, avg_pixel, frame_last);
				errors++;
			end else begin
				seen_want = pending_blocks.pop_front();
				if (seen_want.avg !== avg_pixel) begin
					$display("%0t: avg_pixel expected %0d, got %0d",
						$time, seen_want.avg, avg_pixel);
					errors++;
				end
				if (seen_want.last !== frame_last) begin
					$display("%0t: frame_last expected %0b, got %0b",
						$time, seen_want.last, frame_last);
					errors++;
				end
			end
		end
	end

	function automatic void restart_frame();
		cur_col = 0;
		cur_row = 0;
		blk_x = 0;
		blk_y = 0;
		blk_idx = 0;
	endfunction

	// Accumulate one accepted pixel and queue the average when its block closes
	function automatic void accumulate_pixel(input logic [PIX_W-1:0] px);
		int s, cols, rows, ocols, orows;
		logic [SUM_W-1:0] sum;
		block_avg_t r;
		s = clamp_dim(scale_reg, MAX_SCALE);
		cols = clamp_dim(cols_reg, COL_LIMIT);
		rows = clamp_dim(rows_reg, ROW_LIMIT);
		ocols = cols / s;
		orows = rows / s;
		if (cur_col < ocols * s && cur_row < orows * s) begin
			if (blk_y == 0 && blk_x == 0)
				sum = SUM_W'(px);
			else
				sum = col_sums[blk_idx] + SUM_W'(px);
			col_sums[blk_idx] = sum;
			if (blk_y == s - 1 && blk_x == s - 1) begin
				r.avg = OUT_W'(sum / (s * s));
				r.last = (blk_idx == ocols - 1) && (cur_row == orows * s - 1);
				pending_blocks = {pending_blocks, r};
			end
		end
		// Advance the raster position
		cur_col++;
		blk_x++;
		if (blk_x >= s) begin
			blk_x = 0;
			blk_idx++;
		end
		if (cur_col >= cols) begin
			cur_col = 0;
			blk_x = 0;
			blk_idx = 0;
			cur_row++;
			blk_y++;
			if (blk_y >= s)
				blk_y = 0;
			if (cur_row >= rows) begin
				cur_row = 0;
				blk_y = 0;
			end
		end
	endfunction

	// Offer one pixel, hold it until taken, then predict
	task automatic send_pixel(input logic [PIX_W-1:0] px);
		int gap;
		gap = in_idle_on ? idle_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		pixel <= px;
		do
			@(posedge clk);
		while (!in_ready);
		accumulate_pixel(px);
	endtask

	// Drop valid and let every owed item drain, then let the pipeline settle
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_blocks.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [DIM_W-1:0] val);
		wait_idle();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_SCALE:      scale_reg = val[SCALE_W-1:0];
			REG_IMAGE_COLS: cols_reg = val;
			REG_IMAGE_ROWS: rows_reg = val;
			default: ;
		endcase
		restart_frame();
	endtask

	task automatic set_geometry(input logic [DIM_W-1:0] s, input logic [DIM_W-1:0] cols,
			input logic [DIM_W-1:0] rows);
		write_reg(REG_SCALE, s);
		write_reg(REG_IMAGE_COLS, cols);
		write_reg(REG_IMAGE_ROWS, rows);
	endtask

	// Reset geometry: scale 2 over 640 columns, a short run inside row zero closes no block
	task automatic test_reset_geometry();
		in_idle_on = 1'b0;
		out_idle_on = 1'b1;
		repeat (20) send_pixel(rand_pixel());
	endtask

	// Scale 1: every pixel passes straight through, all-zero and all-one values
	task automatic test_pixel_extremes();
		in_idle_on = 1'b1;
		set_geometry(13'd1, 13'd4, 13'd2);
		send_pixel(16'h0000);
		send_pixel(16'hFFFF);
		send_pixel(16'h0001);
		send_pixel(16'h8000);
		send_pixel(16'hAAAA);
		send_pixel(16'h5555);
		send_pixel(16'hFFFF);
		send_pixel(16'h0000);
	endtask

	// Zero scale and zero dimensions read as one: every pixel is a whole frame
	task automatic test_zero_registers();
		set_geometry(13'd0, 13'd0, 13'd0);
		send_pixel(16'h1234);
		send_pixel(16'hFFFF);
		send_pixel(16'h0000);
	endtask

	// Scale above the limit saturates to 16; a full block of maximum values
	task automatic test_max_block();
		in_idle_on = 1'b0;
		set_geometry(13'h1F, 13'd16, 13'd16);
		repeat (256) send_pixel(16'hFFFF);
		in_idle_on = 1'b1;
	endtask

	// Scale beyond width or height: pixels taken, nothing produced
	task automatic test_no_blocks();
		set_geometry(13'd5, 13'd4, 13'd10);
		repeat (12) send_pixel(rand_pixel());
		set_geometry(13'd3, 13'd10, 13'd2);
		repeat (12) send_pixel(rand_pixel());
	endtask

	// Width and height above the limit saturate
	task automatic test_oversize_dims();
		set_geometry(13'd1, 13'h1FFF, 13'd1);
		repeat (10) send_pixel(rand_pixel());
		set_geometry(13'd2, 13'd2, 13'h1FFF);
		repeat (8) send_pixel(rand_pixel());
	endtask

	// Ragged edges dropped, then the frame wraps into the next one
	task automatic test_ragged_edges();
		set_geometry(13'd3, 13'd7, 13'd7);
		repeat (49 + 21) send_pixel(rand_pixel());
	endtask

	// A write part way through a frame restarts it
	task automatic test_midframe_restart();
		set_geometry(13'd2, 13'd4, 13'd4);
		repeat (5) send_pixel(rand_pixel());
		write_reg(REG_IMAGE_COLS, 13'd4);
		repeat (16) send_pixel(rand_pixel());
	endtask

	// Random geometries, mostly small blocks, each fed up to 60 random pixels
	task automatic test_random_frames();
		int sent, r, es, cols, rows, npx;
		logic [DIM_W-1:0] s_raw;
		sent = 0;
		while (sent < 60) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				s_raw = DIM_W'($urandom_range(1, 4));
			else if (r < 85)
				s_raw = DIM_W'($urandom_range(5, 16));
			else if (r < 92)
				s_raw = '0;
			else
				s_raw = DIM_W'($urandom_range(17, 31));
			es = clamp_dim(s_raw, MAX_SCALE);
			if ($urandom_range(0, 9) == 0) begin
				cols = $urandom_range(0, 40);
				rows = $urandom_range(0, 12);
			end else if (es > 4) begin
				cols = es + $urandom_range(0, 3);
				rows = es + $urandom_range(0, 2);
			end else begin
				cols = es * $urandom_range(1, 5) + $urandom_range(0, es - 1);
				rows = es * $urandom_range(1, 3) + $urandom_range(0, es - 1);
			end
			// Junk in the unused upper bits of the scale write
			s_raw = {DIM_W'($urandom_range(0, 255)) << SCALE_W} | s_raw;
			if ($urandom_range(0, 1)) begin
				write_reg(REG_SCALE, s_raw);
				write_reg(REG_IMAGE_COLS, DIM_W'(cols));
				write_reg(REG_IMAGE_ROWS, DIM_W'(rows));
			end else begin
				write_reg(REG_IMAGE_ROWS, DIM_W'(rows));
				write_reg(REG_IMAGE_COLS, DIM_W'(cols));
				write_reg(REG_SCALE, s_raw);
			end
			in_idle_on = ($urandom_range(0, 3) != 0);
			out_idle_on = ($urandom_range(0, 3) != 0);
			npx = clamp_dim(cols, COL_LIMIT) * clamp_dim(rows, ROW_LIMIT);
			npx = $urandom_range(1, 4) == 1 ? $urandom_range(1, npx) : npx * $urandom_range(1, 2);
			if (npx > 60)
				npx = 60;
			repeat (npx) send_pixel(rand_pixel());
			sent += npx;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_SCALE;
		cfg_wdata = '0;
		in_valid = 1'b0;
		pixel = '0;
		out_ready = 1'b0;
		scale_reg = 5'd2;
		cols_reg = 13'd640;
		rows_reg = 13'd480;
		foreach (col_sums[i])
			col_sums[i] = '0;
		restart_frame();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_geometry();
		test_pixel_extremes();
		test_zero_registers();
		test_max_block();
		test_no_blocks();
		test_oversize_dims();
		test_ragged_edges();
		test_midframe_restart();
		test_random_frames();

		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: box_average_downscale_core.f
src/boxds_pkg.sv
src/boxds_ram.sv
src/box_average_downscale_core.sv
test/testbench.sv
